/* design/dpc_pkg.sv */
// ---------------------------------------------------------------------------
// dpc_pkg
// Shared types and constants of the distinct pattern counter.
// ---------------------------------------------------------------------------
package dpc_pkg;

   typedef enum logic {
      CSR_PATTERN_LENGTH    = 1'b0,
      CSR_LETTER_DIRECTIONS = 1'b1
   } csr_index_type;

   localparam int DIRECTION_BITS = 16;
   localparam int LETTER_WIDTH   = 5;
   localparam int K_WIDTH        = 3;
   localparam int RESULT_WIDTH   = 10;
   localparam logic [K_WIDTH-1:0] K_RESET = 3'd3;

   localparam logic [31:0] FACT_TABLE [0:12] = '{
      32'd1, 32'd1, 32'd2, 32'd6, 32'd24, 32'd120, 32'd720, 32'd5040,
      32'd40320, 32'd362880, 32'd3628800, 32'd39916800, 32'd479001600
   };

endpackage

/* design/distinct_pattern_counter.sv */
// ---------------------------------------------------------------------------
// distinct_pattern_counter
// Counts the distinct k-patterns of a tie-broken letter permutation.
// ---------------------------------------------------------------------------
// Operation: a letter without last is stored and the block stays idle. After
// the last letter the block ranks n positions (one letter memory port), clears
// k! seen bits, then checks each k-subset (one rank memory port, one seen
// read-modify-write) until all subsets or all k! codes are seen; a word shorter
// than k skips all this. The result strobe follows; the receiver cannot stall.
// Reset: synchronous, clears control state and the letter directions, sets the pattern length to K_RESET.
module distinct_pattern_counter #(
   parameter int MAX_WORD_LENGTH    = 64,
   parameter int MAX_PATTERN_LENGTH = 6,
   parameter int MAX_LETTERS        = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [dpc_pkg::LETTER_WIDTH-1:0]    req_letter,
   input  logic                                req_last,
   output logic                                rsp_valid,
   output logic [dpc_pkg::RESULT_WIDTH-1:0]    rsp_distinct_patterns,
   output logic                                rsp_overlong,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  dpc_pkg::csr_index_type              csr_index,
   input  logic [dpc_pkg::DIRECTION_BITS-1:0]  csr_wdata
);

   localparam int IW    = (MAX_WORD_LENGTH > 1) ? $clog2(MAX_WORD_LENGTH) : 1;
   localparam int CW    = $clog2(MAX_WORD_LENGTH + 1);
   localparam int KW    = $clog2(MAX_PATTERN_LENGTH + 1);
   localparam int PIW   = (MAX_PATTERN_LENGTH > 1) ? $clog2(MAX_PATTERN_LENGTH) : 1;
   localparam int PW    = CW + KW + 1;
   localparam int SEEN  = int'(dpc_pkg::FACT_TABLE[MAX_PATTERN_LENGTH]);
   localparam int SW    = (SEEN > 1) ? $clog2(SEEN) : 1;
   localparam int NW    = $clog2(SEEN + 1);
   localparam int LW    = dpc_pkg::LETTER_WIDTH;
   localparam logic [CW-1:0] MAXW = CW'(MAX_WORD_LENGTH);
   localparam logic [KW-1:0] MAXK = KW'(MAX_PATTERN_LENGTH);

   typedef enum logic [3:0] {
      S_LOAD, S_RK_FETCH, S_RK_LATCH, S_RK_SCAN, S_CLEAR, S_EN_ISSUE,
      S_EN_GATHER, S_EN_CODE, S_EN_SUM, S_SEEN_RD, S_SEEN_CHK, S_RESULT
   } state_type;

   state_type                            state_ff;
   logic [dpc_pkg::K_WIDTH-1:0]          k_cfg_ff;
   logic [dpc_pkg::DIRECTION_BITS-1:0]   dir_ff;
   logic [CW-1:0]                        wlen_ff;
   logic                                 ovf_ff;
   logic [KW-1:0]                        k_ff;
   logic [NW-1:0]                        all_ff;
   logic [NW-1:0]                        cnt_ff;
   logic [CW-1:0]                        ri_ff, rj_ff, rjd_ff, rcnt_ff;
   logic [LW-1:0]                        li_ff;
   logic [SW-1:0]                        clr_ff, code_ff;
   logic [KW-1:0]                        ei_ff, eid_ff;
   logic [IW-1:0]                        p_ff [MAX_PATTERN_LENGTH];
   logic [CW-1:0]                        ch_ff [MAX_PATTERN_LENGTH];
   logic [PIW-1:0]                       c_ff [MAX_PATTERN_LENGTH];
   logic                                 rsp_valid_ff;

   logic [LW-1:0]  letter_mem [MAX_WORD_LENGTH];
   logic [CW-1:0]  rank_mem [MAX_WORD_LENGTH];
   logic           seen_mem [SEEN];
   logic [LW-1:0]  letter_q;
   logic [CW-1:0]  rank_q;
   logic           seen_q;

   logic [IW-1:0]  lt_rd_addr, rk_rd_addr;
   logic [CW-1:0]  n_last;
   logic [KW-1:0]  k_eff;
   logic           asc, hit;
   logic [PIW-1:0] c_in [MAX_PATTERN_LENGTH];
   logic [SW-1:0]  code_in;
   logic           adv_found;
   logic [PW-1:0]  adv_base;
   logic [PIW-1:0] adv_d;
   logic [IW-1:0]  p_next [MAX_PATTERN_LENGTH];

   assign busy      = (state_ff != S_LOAD);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_distinct_patterns = dpc_pkg::RESULT_WIDTH'(cnt_ff);
   assign rsp_overlong = ovf_ff;

   assign n_last = (wlen_ff < MAXW) ? wlen_ff + 1'b1 : wlen_ff;

   always_comb begin
      if (k_cfg_ff == '0) begin
         k_eff = KW'(1);
      end else if (KW'(k_cfg_ff) > MAXK || {1'b0, k_cfg_ff} > 4'(MAX_PATTERN_LENGTH)) begin
         k_eff = MAXK;
      end else begin
         k_eff = KW'(k_cfg_ff);
      end
   end

   always_comb begin
      case (state_ff)
         S_RK_FETCH: lt_rd_addr = ri_ff[IW-1:0];
         S_RK_LATCH: lt_rd_addr = '0;
         default:    lt_rd_addr = rj_ff[IW-1:0];
      endcase
      if (state_ff == S_EN_ISSUE) begin
         rk_rd_addr = p_ff[0];
      end else begin
         rk_rd_addr = (ei_ff < MAXK) ? p_ff[ei_ff[PIW-1:0]] : '0;
      end
   end

   always_comb begin
      asc = 1'b0;
      if (li_ff >= LW'(1) && int'(li_ff) <= MAX_LETTERS
          && int'(li_ff) <= dpc_pkg::DIRECTION_BITS) begin
         asc = dir_ff[4'(li_ff - LW'(1))];
      end
      if (rjd_ff == ri_ff) begin
         hit = 1'b0;
      end else if (letter_q != li_ff) begin
         hit = letter_q < li_ff;
      end else begin
         hit = asc ? (rjd_ff < ri_ff) : (rjd_ff > ri_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_PATTERN_LENGTH; i++) begin
         c_in[i] = '0;
         for (int j = i + 1; j < MAX_PATTERN_LENGTH; j++) begin
            if (KW'(j) < k_ff && ch_ff[j] < ch_ff[i]) begin
               c_in[i] = c_in[i] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      code_in = '0;
      for (int i = 0; i < MAX_PATTERN_LENGTH; i++) begin
         if (KW'(i) < k_ff) begin
            code_in = code_in + SW'(c_ff[i] * dpc_pkg::FACT_TABLE[int'(k_ff) - 1 - i]);
         end
      end
   end

   always_comb begin
      adv_found = 1'b0;
      adv_base  = '0;
      adv_d     = '0;
      for (int d = 0; d < MAX_PATTERN_LENGTH; d++) begin
         if (KW'(d) < k_ff
             && PW'(p_ff[d]) + PW'(k_ff) < PW'(wlen_ff) + PW'(d)) begin
            adv_found = 1'b1;
            adv_d     = PIW'(d);
            adv_base  = PW'(p_ff[d]) + PW'(1) - PW'(d);
         end
      end
      for (int j = 0; j < MAX_PATTERN_LENGTH; j++) begin
         p_next[j] = (PIW'(j) >= adv_d) ? IW'(adv_base + PW'(j)) : p_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      letter_q <= letter_mem[lt_rd_addr];
      if (state_ff == S_LOAD && start && wlen_ff < MAXW) begin
         letter_mem[wlen_ff[IW-1:0]] <= req_letter;
      end
   end

   always_ff @(posedge clock) begin
      rank_q <= rank_mem[rk_rd_addr];
      if (state_ff == S_RK_SCAN && rjd_ff == wlen_ff - 1'b1) begin
         rank_mem[ri_ff[IW-1:0]] <= rcnt_ff + CW'(hit);
      end
   end

   always_ff @(posedge clock) begin
      seen_q <= seen_mem[code_ff];
      if (state_ff == S_CLEAR) begin
         seen_mem[clr_ff] <= 1'b0;
      end else if (state_ff == S_SEEN_CHK && !seen_q) begin
         seen_mem[code_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         k_cfg_ff     <= dpc_pkg::K_RESET;
         dir_ff       <= '0;
         wlen_ff      <= '0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dpc_pkg::CSR_PATTERN_LENGTH:    k_cfg_ff <= csr_wdata[dpc_pkg::K_WIDTH-1:0];
               dpc_pkg::CSR_LETTER_DIRECTIONS: dir_ff   <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            S_LOAD: begin
               if (start) begin
                  if (wlen_ff < MAXW) begin
                     wlen_ff <= wlen_ff + 1'b1;
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_last) begin
                     if (wlen_ff == MAXW) begin
                        ovf_ff <= 1'b1;
                     end
                     k_ff   <= k_eff;
                     all_ff <= NW'(dpc_pkg::FACT_TABLE[k_eff]);
                     cnt_ff <= '0;
                     ri_ff  <= '0;
                     clr_ff <= '0;
                     state_ff <= (n_last < CW'(k_eff)) ? S_RESULT : S_RK_FETCH;
                  end
               end
            end
            S_RK_FETCH: state_ff <= S_RK_LATCH;
            S_RK_LATCH: begin
               li_ff   <= letter_q;
               rj_ff   <= CW'(1);
               rjd_ff  <= '0;
               rcnt_ff <= CW'(1);
               state_ff <= S_RK_SCAN;
            end
            S_RK_SCAN: begin
               rcnt_ff <= rcnt_ff + CW'(hit);
               rj_ff   <= rj_ff + 1'b1;
               rjd_ff  <= rjd_ff + 1'b1;
               if (rjd_ff == wlen_ff - 1'b1) begin
                  ri_ff <= ri_ff + 1'b1;
                  state_ff <= (ri_ff == wlen_ff - 1'b1) ? S_CLEAR : S_RK_FETCH;
               end
            end
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (NW'(clr_ff) == all_ff - 1'b1) begin
                  for (int i = 0; i < MAX_PATTERN_LENGTH; i++) begin
                     p_ff[i] <= IW'(i);
                  end
                  state_ff <= S_EN_ISSUE;
               end
            end
            S_EN_ISSUE: begin
               ei_ff  <= KW'(1);
               eid_ff <= '0;
               state_ff <= S_EN_GATHER;
            end
            S_EN_GATHER: begin
               ch_ff[eid_ff[PIW-1:0]] <= rank_q;
               ei_ff  <= ei_ff + 1'b1;
               eid_ff <= eid_ff + 1'b1;
               if (eid_ff == k_ff - 1'b1) begin
                  state_ff <= S_EN_CODE;
               end
            end
            S_EN_CODE: begin
               c_ff <= c_in;
               state_ff <= S_EN_SUM;
            end
            S_EN_SUM: begin
               code_ff <= code_in;
               state_ff <= S_SEEN_RD;
            end
            S_SEEN_RD: state_ff <= S_SEEN_CHK;
            S_SEEN_CHK: begin
               cnt_ff <= cnt_ff + NW'(!seen_q);
               p_ff   <= p_next;
               if (cnt_ff + NW'(!seen_q) == all_ff || !adv_found) begin
                  state_ff <= S_RESULT;
               end else begin
                  state_ff <= S_EN_ISSUE;
               end
            end
            S_RESULT: begin
               rsp_valid_ff <= 1'b1;
               wlen_ff  <= '0;
               state_ff <= S_LOAD;
            end
            default: state_ff <= S_LOAD;
         endcase
         if (rsp_valid_ff) begin
            ovf_ff  <= 1'b0;
         end
      end
   end

endmodule

/* design/dpc_checker.sv */
// ---------------------------------------------------------------------------
// dpc_checker
// Port-level checks of the distinct pattern counter.
// ---------------------------------------------------------------------------
module dpc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last,
   input logic rsp_valid
);

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid) else $error("busy after reset");

   a_rsp_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy while result shown");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_last |=> !busy && !rsp_valid)
      else $error("non-final letter not absorbed in one cycle");

   a_last_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last |=> busy) else $error("final letter ignored");

endmodule

bind distinct_pattern_counter dpc_checker u_dpc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_last  (req_last),
   .rsp_valid (rsp_valid)
);
